// File: rtl/core/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int NUM_TRACKS        = 128;
    localparam int SECTORS_PER_TRACK = 4096;
    localparam int SECTOR_BYTES      = 512;
    localparam int MAX_SECTORS       = 20;

    localparam int WORD_BITS     = 64;
    localparam int TOTAL_SECTORS = NUM_TRACKS * SECTORS_PER_TRACK;
    localparam int MAP_WORDS     = (TOTAL_SECTORS + WORD_BITS - 1) / WORD_BITS;

    localparam int ADDR_W   = $clog2(MAP_WORDS);
    localparam int FILL_W   = $clog2(MAP_WORDS + 1);
    localparam int BIT_W    = $clog2(WORD_BITS);
    localparam int LIN_W    = ADDR_W + BIT_W;
    localparam int TRACK_W  = 7;
    localparam int SECTOR_W = 12;
    localparam int BYTES_W  = 14;
    localparam int NEED_W   = $clog2(MAX_SECTORS + 1);
    localparam int SHIFT_W  = $clog2(SECTOR_BYTES);
    localparam int RAW_W    = BYTES_W + 1 - SHIFT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SCAN,
        ST_WRITE,
        ST_FINAL
    } bsa_state_t;

    typedef struct packed {
        logic load;
        logic set_bit;
        logic advance;
    } scan_ctl_t;

    typedef struct packed {
        logic             bit_free;
        logic             at_end;
        logic [BIT_W-1:0] bit_idx;
    } scan_sts_t;

endpackage

// File: rtl/core/bsa_if.sv
`timescale 1ns / 1ps

interface bsa_req_if;
    import bsa_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTES_W-1:0] byte_count;

    modport source (output valid, output byte_count, input ready);
    modport sink   (input valid, input byte_count, output ready);
endinterface

interface bsa_rsp_if;
    import bsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [TRACK_W-1:0]  track;
    logic [SECTOR_W-1:0] sector;
    logic                sector_valid;
    logic                last;
    logic                status;

    modport source (output valid, output track, output sector, output sector_valid,
                    output last, output status, input ready);
    modport sink   (input valid, input track, input sector, input sector_valid,
                    input last, input status, output ready);
endinterface

// File: rtl/core/bsa_map_ram.sv
`timescale 1ns / 1ps

module bsa_map_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/bsa_word_scan.sv
`timescale 1ns / 1ps

module bsa_word_scan (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bsa_pkg::scan_ctl_t                ctl,
    input  logic [bsa_pkg::WORD_BITS-1:0]     load_word,
    output bsa_pkg::scan_sts_t                sts,
    output logic [bsa_pkg::WORD_BITS-1:0]     word
);
    import bsa_pkg::*;

    logic [WORD_BITS-1:0] word_reg;
    logic [BIT_W-1:0]     bit_reg;

    // Hold the word under test; mark the current bit when told to.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            word_reg <= load_word;
        end
        else if (ctl.set_bit)
        begin
            word_reg[bit_reg] <= 1'b1;
        end
    end

    // Bit pointer: restart on load, advance one bit per step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= '0;
        end
        else if (ctl.load)
        begin
            bit_reg <= '0;
        end
        else if (ctl.advance)
        begin
            bit_reg <= bit_reg + BIT_W'(1);
        end
    end

    assign sts.bit_free = ~word_reg[bit_reg];
    assign sts.at_end   = (bit_reg == BIT_W'(WORD_BITS - 1));
    assign sts.bit_idx  = bit_reg;
    assign word         = word_reg;

endmodule

// File: rtl/core/bitmap_sector_allocator_unit.sv
`timescale 1ns / 1ps

// First-fit bitmap sector allocator.
// request channel: one byte_count per request; the block needs
// ceil(byte_count / 512) sectors, capped at 20. request.ready is high only
// while the sequencer is idle, so one request is in flight at a time.
// result channel: one result per allocated sector (track, sector,
// sector_valid = 1), the final one flagged with last. A zero-byte request
// gives a single empty last result. When the disk runs out, the sectors
// found so far are reported with last = 0, then one empty result with
// last = 1 and status = 1; those sectors stay used.
// Timing: the used-sector bitmap sits in a 64-bit-wide word memory and is
// tested by a single bit-scan unit, from bit 0 of each word, one bit per
// cycle while the result receiver does not stall. A request is accepted
// in idle, then each map word touched is read, loaded, scanned over the
// bits visited (up to 64) and written back; with space left it touches at
// most two words; a pointer to the first non-full word skips filled words.
// Reset clears the bitmap logically: a fill count marks how many leading
// words have been written, and words at or past it read as free, so no
// clearing pass is needed and requests are taken right after reset.
// A stalled result receiver holds the scan on the next free sector until
// the single-entry output register drains.
module bitmap_sector_allocator_unit (
    input  logic      clk,
    input  logic      rst_n,
    bsa_req_if.sink   request,
    bsa_rsp_if.source result
);
    import bsa_pkg::*;

    bsa_state_t state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] hint_reg, hint_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [NEED_W-1:0] got_reg, got_next;
    logic              fail_reg, fail_next;

    logic                out_valid_reg, out_valid_next;
    logic [TRACK_W-1:0]  track_reg, track_next;
    logic [SECTOR_W-1:0] sector_reg, sector_next;
    logic                sector_valid_reg, sector_valid_next;
    logic                last_reg, last_next;
    logic                status_reg, status_next;

    scan_ctl_t            scan_ctl;
    scan_sts_t            scan_sts;
    logic [WORD_BITS-1:0] scan_word;
    logic [WORD_BITS-1:0] load_word;
    logic [WORD_BITS-1:0] rd_data;
    logic                 rd_en;
    logic                 wr_en;

    logic [BYTES_W:0]   bytes_round;
    logic [RAW_W-1:0]   need_raw;
    logic [NEED_W-1:0]  need_sat;
    logic [NEED_W-1:0]  got_inc;
    logic [LIN_W-1:0]   lin_idx;
    logic               slot_free;
    logic               word_full;

    bsa_map_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_BITS)
    ) u_map_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (scan_word)
    );

    bsa_word_scan u_word_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .load_word (load_word),
        .sts       (scan_sts),
        .word      (scan_word)
    );

    // Round the byte count up to whole sectors and cap at the request limit.
    assign bytes_round = {1'b0, request.byte_count} + (BYTES_W + 1)'(SECTOR_BYTES - 1);
    assign need_raw    = bytes_round[BYTES_W:SHIFT_W];
    assign need_sat    = (need_raw > RAW_W'(MAX_SECTORS)) ? NEED_W'(MAX_SECTORS)
                                                          : NEED_W'(need_raw);

    // Words at or beyond the fill count were never written: treat as free.
    assign load_word = ({1'b0, addr_reg} < fill_reg) ? rd_data : '0;

    assign got_inc   = got_reg + NEED_W'(1);
    assign lin_idx   = {addr_reg, scan_sts.bit_idx};
    assign slot_free = !out_valid_reg || result.ready;
    assign word_full = &scan_word;

    assign request.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        addr_next         = addr_reg;
        fill_next         = fill_reg;
        hint_next         = hint_reg;
        need_next         = need_reg;
        got_next          = got_reg;
        fail_next         = fail_reg;
        scan_ctl          = '0;
        rd_en             = 1'b0;
        wr_en             = 1'b0;

        // Drain the output register when the receiver takes the result.
        out_valid_next    = out_valid_reg && !result.ready;
        track_next        = track_reg;
        sector_next       = sector_reg;
        sector_valid_next = sector_valid_reg;
        last_next         = last_reg;
        status_next       = status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    need_next = need_sat;
                    got_next  = '0;
                    addr_next = hint_reg[ADDR_W-1:0];
                    if (need_sat == '0)
                    begin
                        fail_next  = 1'b0;
                        state_next = ST_FINAL;
                    end
                    else if (hint_reg == FILL_W'(MAP_WORDS))
                    begin
                        fail_next  = 1'b1;
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                scan_ctl.load = 1'b1;
                state_next    = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (scan_sts.bit_free)
                begin
                    // Claim this sector once the output register has room.
                    if (slot_free)
                    begin
                        scan_ctl.set_bit  = 1'b1;
                        got_next          = got_inc;
                        out_valid_next    = 1'b1;
                        track_next        = lin_idx[SECTOR_W +: TRACK_W];
                        sector_next       = lin_idx[SECTOR_W-1:0];
                        sector_valid_next = 1'b1;
                        last_next         = (got_inc == need_reg);
                        status_next       = 1'b0;
                        if (got_inc == need_reg || scan_sts.at_end)
                        begin
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            scan_ctl.advance = 1'b1;
                        end
                    end
                end
                else if (scan_sts.at_end)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    scan_ctl.advance = 1'b1;
                end
            end

            ST_WRITE:
            begin
                wr_en = 1'b1;
                if ({1'b0, addr_reg} >= fill_reg)
                begin
                    fill_next = FILL_W'(addr_reg) + FILL_W'(1);
                end
                if (word_full && ({1'b0, addr_reg} == hint_reg))
                begin
                    hint_next = FILL_W'(addr_reg) + FILL_W'(1);
                end
                if (got_reg == need_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (addr_reg == ADDR_W'(MAP_WORDS - 1))
                begin
                    fail_next  = 1'b1;
                    state_next = ST_FINAL;
                end
                else
                begin
                    addr_next  = addr_reg + ADDR_W'(1);
                    state_next = ST_READ;
                end
            end

            ST_FINAL:
            begin
                // Empty closing result: zero-byte request or out of space.
                if (slot_free)
                begin
                    out_valid_next    = 1'b1;
                    track_next        = '0;
                    sector_next       = '0;
                    sector_valid_next = 1'b0;
                    last_next         = 1'b1;
                    status_next       = fail_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            fill_reg      <= '0;
            hint_reg      <= '0;
            need_reg      <= '0;
            got_reg       <= '0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            fill_reg      <= fill_next;
            hint_reg      <= hint_next;
            need_reg      <= need_next;
            got_reg       <= got_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: loaded only together with out_valid_reg.
    always_ff @(posedge clk)
    begin
        track_reg        <= track_next;
        sector_reg       <= sector_next;
        sector_valid_reg <= sector_valid_next;
        last_reg         <= last_next;
        status_reg       <= status_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.track        = track_reg;
    assign result.sector       = sector_reg;
    assign result.sector_valid = sector_valid_reg;
    assign result.last         = last_reg;
    assign result.status       = status_reg;

endmodule
